// ----- src/psp_pkg.sv -----
// ----------------------------------------------------------------------------
// Power state select policy package
// Shared request and response types, command and register codes, and
// fixed constants of the power state selection policy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psp_pkg;

	// Width of a state identifier and the number of states it can name.
	localparam int SID_W    = 3;
	localparam int SID_SPAN = 1 << SID_W;

	// Microseconds per second, and the suspend-to-RAM exit latency and
	// minimum residency in microseconds.
	localparam int US_W = 20;
	localparam logic [US_W-1:0] US_PER_SEC   = 20'd1000000;
	localparam int              RAM_EXIT_US  = 1400;
	localparam int              RAM_RESID_US = 100;

	// A wait of all ones means the next timeout never comes.
	localparam logic [31:0] FOREVER_TICKS = 32'hFFFF_FFFF;

	// Split of the 53-bit reciprocal into two partial multiplier operands.
	localparam int MAG_W    = 53;
	localparam int MAG_LO_W = 27;
	localparam int MAG_HI_W = MAG_W - MAG_LO_W;

	// Width of the residency limit in microseconds (13-bit seconds times 1e6).
	localparam int LIMIT_US_W = 33;

	// Power state codes.
	localparam logic [SID_W-1:0] ST_ACTIVE = 3'd0;
	localparam logic [SID_W-1:0] ST_IDLE   = 3'd2;
	localparam logic [SID_W-1:0] ST_RAM    = 3'd4;

	typedef enum logic [1:0] {
		CMD_CHOOSE = 2'd0,
		CMD_GET    = 2'd1,
		CMD_PUT    = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_IDLE_THR   = 2'd0,
		CFG_ACTIVE_THR = 2'd1,
		CFG_GUARD_ON   = 2'd2,
		CFG_LIMIT_SEC  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		cmd_t             command;
		logic [31:0]      wait_ticks;
		logic [SID_W-1:0] state_id;
	} req_t;

	typedef struct packed {
		logic             state_found;
		logic [SID_W-1:0] chosen_state;
		logic [10:0]      exit_latency;
		logic [6:0]       min_residency;
		logic             lock_active;
		logic             unbalanced_put;
	} rsp_t;

	// One update of the lock counter table.
	typedef struct packed {
		logic             en;
		cmd_t             cmd;
		logic [SID_W-1:0] sid;
	} lock_op_t;

endpackage

// ----- src/psp_lock_tbl.sv -----
// ----------------------------------------------------------------------------
// Power state lock counter table
// One saturating up/down counter per power state, with a nonzero flag per
// addressable state for query and choose.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psp_lock_tbl #(
	parameter int NUM_STATES = 7,
	parameter int LOCK_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psp_pkg::lock_op_t             op,
	output logic [psp_pkg::SID_SPAN-1:0]  nz
);

	// States above the reach of a state identifier can never be addressed.
	localparam int TABLE_DEPTH = (NUM_STATES < psp_pkg::SID_SPAN) ?
		NUM_STATES : psp_pkg::SID_SPAN;

	logic [LOCK_WIDTH-1:0] cnt_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] sel;

	for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cnt
		assign sel[gi] = op.en && (op.sid == psp_pkg::SID_W'(gi));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[gi] <= '0;
			end else if (sel[gi]) begin
				case (op.cmd)
					psp_pkg::CMD_GET: begin
						if (!(&cnt_q[gi])) begin
							cnt_q[gi] <= cnt_q[gi] + LOCK_WIDTH'(1);
						end
					end
					psp_pkg::CMD_PUT: begin
						if (|cnt_q[gi]) begin
							cnt_q[gi] <= cnt_q[gi] - LOCK_WIDTH'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	for (genvar gi = 0; gi < psp_pkg::SID_SPAN; gi++) begin : g_nz
		if (gi < TABLE_DEPTH) begin : g_in
			assign nz[gi] = |cnt_q[gi];
		end else begin : g_out
			assign nz[gi] = 1'b0;
		end
	end

	for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_chk
		// A counter only moves when its own state is addressed.
		a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
			!sel[gi] |=> $stable(cnt_q[gi]))
			else $error("lock counter changed without being addressed");

		// A put on an empty counter leaves it empty.
		a_put_floor: assert property (@(posedge clk) disable iff (!arst_n)
			(sel[gi] && op.cmd == psp_pkg::CMD_PUT && cnt_q[gi] == '0)
			|=> cnt_q[gi] == '0)
			else $error("lock counter wrapped below zero");

		// A get below the ceiling counts up by exactly one.
		a_get_step: assert property (@(posedge clk) disable iff (!arst_n)
			(sel[gi] && op.cmd == psp_pkg::CMD_GET && !(&cnt_q[gi]))
			|=> cnt_q[gi] == $past(cnt_q[gi]) + LOCK_WIDTH'(1))
			else $error("lock counter get did not step by one");
	end

endmodule

// ----- src/power_state_select_policy.sv -----
// ----------------------------------------------------------------------------
// Power state select policy: one response per request, carried through the
// request register, then two more pipeline stages and the response register.
// Takes one request per cycle while the response side does not stall; the
// tick-to-microsecond multiply is split over two stages. Reset clears all
// lock counters and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module power_state_select_policy #(
	parameter int NUM_STATES       = 7,
	parameter int TICKS_PER_SECOND = 32000,
	parameter int LOCK_WIDTH       = 16
) (
	input  logic           clk,
	input  logic           arst_n,

	input  logic           req_valid,
	output logic           req_stall,
	input  psp_pkg::req_t  req_data,

	output logic           rsp_valid,
	input  logic           rsp_stall,
	output psp_pkg::rsp_t  rsp_data,

	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [31:0]    cfg_data
);

	// ------------------------------------------------------------------
	// Constants derived from the tick rate.
	//
	// The microsecond count is floor(ticks * 1e6 / rate). It is formed as
	// (ticks * MAG) >> SHIFT with MAG = ceil(2^SHIFT * 1e6 / rate). With
	// SHIFT = 32 + clog2(rate) the rounding error of MAG, times any 32-bit
	// tick count, stays below 1/rate, so the floor is exact. MAG always
	// fits in 53 bits and is split into two operands of 27 and 26 bits.
	// ------------------------------------------------------------------
	localparam int SHIFT = 32 + $clog2(TICKS_PER_SECOND);
	localparam logic [95:0] MAG =
		(((96'd1 << SHIFT) * 96'd1000000) + 96'(TICKS_PER_SECOND) - 96'd1) /
		96'(TICKS_PER_SECOND);
	localparam logic [psp_pkg::MAG_LO_W-1:0] MAG_LO = MAG[psp_pkg::MAG_LO_W-1:0];
	localparam logic [psp_pkg::MAG_HI_W-1:0] MAG_HI =
		MAG[psp_pkg::MAG_W-1:psp_pkg::MAG_LO_W];

	localparam int PROD_W = 32 + psp_pkg::MAG_W - 1 + 1;

	// Suspend-to-RAM exit latency and minimum residency in ticks, rounded up.
	localparam int LAT_TICKS =
		(psp_pkg::RAM_EXIT_US * TICKS_PER_SECOND + 999999) / 1000000;
	localparam int RES_TICKS =
		(psp_pkg::RAM_RESID_US * TICKS_PER_SECOND + 999999) / 1000000;
	localparam logic [31:0] MIN_WAIT = 32'(LAT_TICKS + RES_TICKS);

	// ------------------------------------------------------------------
	// Configuration registers. The residency limit is kept a second time
	// in microseconds, recomputed every cycle from the seconds value; it
	// settles the cycle after a write, so a request in flight may miss it.
	// ------------------------------------------------------------------
	logic [31:0]                      idle_thr_q;
	logic [31:0]                      active_thr_q;
	logic                             guard_on_q;
	logic [12:0]                      limit_sec_q;
	logic [psp_pkg::LIMIT_US_W-1:0]   limit_us_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_thr_q   <= 32'd2000;
			active_thr_q <= 32'd1000;
			guard_on_q   <= 1'b1;
			limit_sec_q  <= 13'd3600;
		end else if (cfg_we) begin
			case (psp_pkg::cfg_idx_t'(cfg_index))
				psp_pkg::CFG_IDLE_THR:   idle_thr_q   <= cfg_data;
				psp_pkg::CFG_ACTIVE_THR: active_thr_q <= cfg_data;
				psp_pkg::CFG_GUARD_ON:   guard_on_q   <= cfg_data[0];
				psp_pkg::CFG_LIMIT_SEC:  limit_sec_q  <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_us_q <= 33'd3600000000;
		end else begin
			limit_us_q <= psp_pkg::LIMIT_US_W'(limit_sec_q) *
				psp_pkg::LIMIT_US_W'(psp_pkg::US_PER_SEC);
		end
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. Each stage takes a new request when it is
	// empty or when the stage after it takes its current one, so bubbles
	// close up and a stalled response does not block stages that are free.
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3;
	logic rsp_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;

	assign rdy_out = !rsp_valid_q || !rsp_stall;
	assign rdy_s3  = !vld_s3 || rdy_out;
	assign rdy_s2  = !vld_s2 || rdy_s3;
	assign rdy_s1  = !vld_s1 || rdy_s2;

	assign req_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= req_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_out) begin
				rsp_valid_q <= vld_s3;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the request register.
	// Stage 2: two partial products of the ticks and the reciprocal.
	// Stage 3: the partial products summed and the microseconds selected.
	// ------------------------------------------------------------------
	psp_pkg::req_t req_s1, req_s2, req_s3;
	logic [32+psp_pkg::MAG_LO_W-1:0] pp_lo_s2;
	logic [32+psp_pkg::MAG_HI_W-1:0] pp_hi_s2;
	logic [31:0]                     usecs_s3;
	logic [PROD_W-1:0]               prod_full;

	always_ff @(posedge clk) begin
		if (rdy_s1 && req_valid) begin
			req_s1 <= req_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			req_s2   <= req_s1;
			pp_lo_s2 <= (32 + psp_pkg::MAG_LO_W)'(req_s1.wait_ticks) *
				(32 + psp_pkg::MAG_LO_W)'(MAG_LO);
			pp_hi_s2 <= (32 + psp_pkg::MAG_HI_W)'(req_s1.wait_ticks) *
				(32 + psp_pkg::MAG_HI_W)'(MAG_HI);
		end
	end

	assign prod_full = {pp_hi_s2, {psp_pkg::MAG_LO_W{1'b0}}} +
		PROD_W'(pp_lo_s2);

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			req_s3   <= req_s2;
			usecs_s3 <= prod_full[SHIFT +: 32];
		end
	end

	// ------------------------------------------------------------------
	// Lock counter table. It is read and updated only as a request leaves
	// stage 3, so choose always sees every earlier get and put.
	// ------------------------------------------------------------------
	psp_pkg::lock_op_t              lock_op;
	logic [psp_pkg::SID_SPAN-1:0]   lock_nz;
	logic                           in_tbl;

	assign in_tbl = int'(req_s3.state_id) < NUM_STATES;

	assign lock_op.en  = vld_s3 && rdy_out && in_tbl &&
		(req_s3.command != psp_pkg::CMD_CHOOSE);
	assign lock_op.cmd = req_s3.command;
	assign lock_op.sid = req_s3.state_id;

	psp_lock_tbl #(
		.NUM_STATES (NUM_STATES),
		.LOCK_WIDTH (LOCK_WIDTH)
	) u_lock_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (lock_op),
		.nz     (lock_nz)
	);

	// ------------------------------------------------------------------
	// State choice. A wait above the idle threshold picks suspend to RAM,
	// otherwise one at or above the active threshold picks suspend to
	// idle, otherwise active. The pick is dropped when the residency guard
	// trips, when the state is locked, or when a finite wait is shorter
	// than the exit latency plus minimum residency. States outside the
	// table read as unlocked, since their nonzero flags are tied low.
	// ------------------------------------------------------------------
	logic [psp_pkg::SID_W-1:0] pick_st;
	logic [10:0]               pick_lat;
	logic [6:0]                pick_res;
	logic                      guard_trip;
	logic                      wait_ok;
	logic                      pick_ok;
	psp_pkg::rsp_t             rsp_d;
	psp_pkg::rsp_t             rsp_q;

	always_comb begin
		if (usecs_s3 > idle_thr_q) begin
			pick_st  = psp_pkg::ST_RAM;
			pick_lat = 11'(LAT_TICKS);
			pick_res = 7'(RES_TICKS);
		end else if (usecs_s3 >= active_thr_q) begin
			pick_st  = psp_pkg::ST_IDLE;
			pick_lat = '0;
			pick_res = '0;
		end else begin
			pick_st  = psp_pkg::ST_ACTIVE;
			pick_lat = '0;
			pick_res = '0;
		end
	end

	assign guard_trip = guard_on_q &&
		({1'b0, usecs_s3} > limit_us_q);

	// Only suspend to RAM carries a nonzero latency and residency, so the
	// length check against the fixed sum applies to that pick alone.
	assign wait_ok = (req_s3.wait_ticks == psp_pkg::FOREVER_TICKS) ||
		(pick_st != psp_pkg::ST_RAM) || (req_s3.wait_ticks >= MIN_WAIT);

	assign pick_ok = !guard_trip && !lock_nz[pick_st] && wait_ok;

	always_comb begin
		rsp_d = '0;
		case (req_s3.command)
			psp_pkg::CMD_CHOOSE: begin
				if (pick_ok) begin
					rsp_d.state_found   = 1'b1;
					rsp_d.chosen_state  = pick_st;
					rsp_d.exit_latency  = pick_lat;
					rsp_d.min_residency = pick_res;
				end
			end
			psp_pkg::CMD_PUT: begin
				rsp_d.unbalanced_put = in_tbl && !lock_nz[req_s3.state_id];
			end
			psp_pkg::CMD_QUERY: begin
				rsp_d.lock_active = lock_nz[req_s3.state_id];
			end
			default: begin
			end
		endcase
	end

	// Response register: it holds a finished response while the far side
	// stalls, and the stages behind it keep filling meanwhile.
	always_ff @(posedge clk) begin
		if (rdy_out && vld_s3) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
